FILE: hw/rtl/dhl_pkg.sv
// dhl_pkg: shared widths, codes and command/status structs for the
// double-hashing lookup/insert table; no dependencies

package dhl_pkg;

   localparam int KEY_W        = 31;
   localparam int FRAC_W       = 32;
   localparam int SIZE_W       = 11;
   localparam int SLOT_W       = 10;
   localparam int STAT_W       = 2;
   localparam int ENTRY_W      = KEY_W + 1;
   localparam int SIZE_MAX     = (1 << SIZE_W) - 1;
   localparam int MAX_SLOTS_DEF = 1024;

   // remainder unit: bits retired per cycle and steps per key
   localparam int DIV_BITS     = 4;
   localparam int DIV_STEPS    = (KEY_W + DIV_BITS - 1) / DIV_BITS;
   localparam int DIVIDEND_W   = DIV_STEPS * DIV_BITS;
   localparam int DIV_CNT_W    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

   // configuration port
   localparam int CSR_IDX_W    = 1;
   localparam int CSR_DATA_W   = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_MULT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE = 1'd1;
   localparam logic [FRAC_W-1:0] MULT_RESET = 32'd2654435769;
   localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

   typedef enum logic [STAT_W-1:0] {
      ST_FOUND    = 2'd0,
      ST_INSERTED = 2'd1,
      ST_FULL     = 2'd2
   } dhl_status_type;

   typedef struct packed {
      logic           clear_wr;
      logic           load_key;
      logic           start_probe;
      logic           insert;
      logic           advance;
      logic           set_result;
      dhl_status_type result_status;
      logic           load_rsp;
   } dhl_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic rem_done;
      logic entry_used;
      logic key_match;
      logic probe_last;
   } dhl_sts_type;

endpackage

FILE: hw/rtl/dhl_rem.sv
// dhl_rem: iterative remainder unit, key mod a runtime divisor,
// DIV_BITS quotient bits per cycle; depends on dhl_pkg

module dhl_rem import dhl_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [KEY_W-1:0]  dividend,
   input  logic [SIZE_W-1:0] divisor,
   output logic              done,
   output logic [SIZE_W-1:0] remainder
);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIV_CNT_W-1:0]  step_ff, step_in;
   logic [DIVIDEND_W-1:0] num_ff, num_in;
   logic [SIZE_W-1:0]     div_ff, div_in;
   logic [SIZE_W-1:0]     rem_ff, rem_in;
   logic [SIZE_W-1:0]     rem_step;

   // restoring division over the top DIV_BITS bits of the shifting dividend
   always_comb begin
      logic [SIZE_W:0] t;
      logic [SIZE_W-1:0] r;
      r = rem_ff;
      for (int j = 0; j < DIV_BITS; j++) begin
         t = {r, num_ff[DIVIDEND_W-1-j]};
         if (t >= {1'b0, div_ff}) begin
            t = t - {1'b0, div_ff};
         end
         r = t[SIZE_W-1:0];
      end
      rem_step = r;
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      step_in = step_ff;
      num_in  = num_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         step_in = '0;
         num_in  = DIVIDEND_W'(dividend);
         div_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in  = rem_step;
         num_in  = num_ff << DIV_BITS;
         step_in = step_ff + DIV_CNT_W'(1);
         if (step_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      num_ff <= num_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

FILE: hw/rtl/dhl_ctrl.sv
// dhl_ctrl: controller state machine for clearing, hashing, probing and
// response handoff; depends on dhl_pkg

module dhl_ctrl import dhl_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   input  dhl_sts_type sts,
   output dhl_cmd_type cmd
);

   typedef enum logic [5:0] {
      S_CLEAR   = 6'b000001,
      S_IDLE    = 6'b000010,
      S_HASH    = 6'b000100,
      S_READ    = 6'b001000,
      S_CHECK   = 6'b010000,
      S_DELIVER = 6'b100000
   } dhl_state_type;

   dhl_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd = '0;
      cmd.result_status = ST_FOUND;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (sts.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_key = 1'b1;
               state_in = S_HASH;
            end
         end
         S_HASH: begin
            if (sts.rem_done) begin
               cmd.start_probe = 1'b1;
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (!sts.entry_used) begin
               cmd.insert = 1'b1;
               cmd.set_result = 1'b1;
               cmd.result_status = ST_INSERTED;
               state_in = S_DELIVER;
            end else if (sts.key_match) begin
               cmd.set_result = 1'b1;
               cmd.result_status = ST_FOUND;
               state_in = S_DELIVER;
            end else if (sts.probe_last) begin
               cmd.set_result = 1'b1;
               cmd.result_status = ST_FULL;
               state_in = S_DELIVER;
            end else begin
               cmd.advance = 1'b1;
               state_in = S_READ;
            end
         end
         S_DELIVER: begin
            if (out_free) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: hw/rtl/dhl_dp.sv
// dhl_dp: datapath with configuration registers, hash multipliers, probe
// stepping and the slot memory; depends on dhl_pkg and dhl_rem

module dhl_dp import dhl_pkg::*; #(
   parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic [KEY_W-1:0]      req_key,
   input  dhl_cmd_type           cmd,
   output dhl_sts_type           sts,
   output logic [SLOT_W-1:0]     rsp_slot,
   output logic [STAT_W-1:0]     rsp_status
);

   localparam int ADDR_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int CAP = (MAX_SLOTS < SIZE_MAX) ? MAX_SLOTS : SIZE_MAX;
   localparam logic [SIZE_W-1:0] CAP_B = SIZE_W'(CAP);
   localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(MAX_SLOTS - 1);

   logic [FRAC_W-1:0]    mult_ff, mult_in;
   logic [SIZE_W-1:0]    size_ff, size_in;
   logic [KEY_W-1:0]     key_ff, key_in;
   logic [FRAC_W-1:0]    frac_ff, frac_in;
   logic [SIZE_W-1:0]    h1_ff, h1_in;
   logic [SIZE_W-1:0]    h2_ff, h2_in;
   logic [SIZE_W-1:0]    idx_ff, idx_in;
   logic [SIZE_W-1:0]    cnt_ff, cnt_in;
   logic [ADDR_W-1:0]    clr_ff, clr_in;
   logic [ENTRY_W-1:0]   rdata_ff;
   logic [SLOT_W-1:0]    res_slot_ff, res_slot_in;
   dhl_status_type       res_status_ff, res_status_in;
   logic [SLOT_W-1:0]    rsp_slot_ff, rsp_slot_in;
   dhl_status_type       rsp_status_ff, rsp_status_in;

   logic [ENTRY_W-1:0]   slot_mem [MAX_SLOTS];

   logic [SIZE_W-1:0]        b_eff;
   logic [SIZE_W-1:0]        divisor;
   logic [SIZE_W-1:0]        rem;
   logic                     rem_done;
   logic [KEY_W+FRAC_W-1:0]  prod_key;
   logic [SIZE_W+FRAC_W-1:0] prod_b;
   logic [SIZE_W:0]          sum;
   logic [SIZE_W:0]          sum_wrap;
   logic [ADDR_W-1:0]        probe_addr;
   logic [ADDR_W-1:0]        wr_addr;
   logic [ENTRY_W-1:0]       wr_data;
   logic                     wr_en;

   // slot count in use, held between two and the built capacity
   always_comb begin
      if (size_ff < SIZE_W'(2)) begin
         b_eff = SIZE_W'(2);
      end else if (size_ff > CAP_B) begin
         b_eff = CAP_B;
      end else begin
         b_eff = size_ff;
      end
   end

   assign divisor = b_eff - SIZE_W'(1);

   dhl_rem u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.load_key),
      .dividend  (req_key),
      .divisor   (divisor),
      .done      (rem_done),
      .remainder (rem)
   );

   // multiplicative hash, one product per register stage
   assign prod_key = {{FRAC_W{1'b0}}, key_ff} * {{KEY_W{1'b0}}, mult_ff};
   assign frac_in  = prod_key[FRAC_W-1:0];
   assign prod_b   = {{FRAC_W{1'b0}}, b_eff} * {{SIZE_W{1'b0}}, frac_ff};
   assign h1_in    = prod_b[SIZE_W+FRAC_W-1:FRAC_W];

   // next probe index modulo b, one compare and subtract
   assign sum      = {1'b0, idx_ff} + {1'b0, h2_ff};
   assign sum_wrap = (sum >= {1'b0, b_eff}) ? (sum - {1'b0, b_eff}) : sum;

   always_comb begin
      mult_in = mult_ff;
      size_in = size_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_MULT: mult_in = csr_wdata[FRAC_W-1:0];
            CSR_SIZE: size_in = csr_wdata[SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      key_in        = key_ff;
      h2_in         = h2_ff;
      idx_in        = idx_ff;
      cnt_in        = cnt_ff;
      clr_in        = clr_ff;
      res_slot_in   = res_slot_ff;
      res_status_in = res_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_status_in = rsp_status_ff;
      if (cmd.clear_wr) begin
         clr_in = clr_ff + ADDR_W'(1);
      end
      if (cmd.load_key) begin
         key_in = req_key;
      end
      if (cmd.start_probe) begin
         h2_in  = rem + SIZE_W'(1);
         idx_in = h1_ff;
         cnt_in = '0;
      end
      if (cmd.advance) begin
         idx_in = sum_wrap[SIZE_W-1:0];
         cnt_in = cnt_ff + SIZE_W'(1);
      end
      if (cmd.set_result) begin
         res_status_in = cmd.result_status;
         res_slot_in   = (cmd.result_status == ST_FULL) ? '0 : idx_ff[SLOT_W-1:0];
      end
      if (cmd.load_rsp) begin
         rsp_slot_in   = res_slot_ff;
         rsp_status_in = res_status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mult_ff <= MULT_RESET;
         size_ff <= SIZE_RESET;
         clr_ff  <= '0;
      end else begin
         mult_ff <= mult_in;
         size_ff <= size_in;
         clr_ff  <= clr_in;
      end
      key_ff        <= key_in;
      frac_ff       <= frac_in;
      h1_ff         <= h1_in;
      h2_ff         <= h2_in;
      idx_ff        <= idx_in;
      cnt_ff        <= cnt_in;
      res_slot_ff   <= res_slot_in;
      res_status_ff <= res_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_status_ff <= rsp_status_in;
   end

   // slot memory: one write port, one registered read port
   assign probe_addr = ADDR_W'(idx_ff);
   assign wr_en      = cmd.clear_wr | cmd.insert;
   assign wr_addr    = cmd.clear_wr ? clr_ff : probe_addr;
   assign wr_data    = cmd.clear_wr ? '0 : {1'b1, key_ff};

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_data;
      end
      rdata_ff <= slot_mem[probe_addr];
   end

   assign sts.clear_last = (clr_ff == CLR_LAST);
   assign sts.rem_done   = rem_done;
   assign sts.entry_used = rdata_ff[ENTRY_W-1];
   assign sts.key_match  = (rdata_ff[KEY_W-1:0] == key_ff);
   assign sts.probe_last = (cnt_ff == divisor);

   assign rsp_slot   = rsp_slot_ff;
   assign rsp_status = rsp_status_ff;

endmodule

FILE: hw/rtl/double_hash_lookup_insert.sv
// double_hash_lookup_insert: top level of the open-addressing hash table
// with double hashing; depends on dhl_pkg, dhl_ctrl and dhl_dp
//
// Each request carries a key; the block walks slots (h1 + i*h2) mod B and
// answers found, inserted or full with the slot index. After reset the slot
// memory is swept clear, one entry a cycle, during which requests stall
// (configuration writes are still taken). A request then passes through the
// key mod (B-1) remainder unit, which retires four bits a cycle, and then
// through one registered read of the slot memory and one check per probe.
// One request is worked on at a time; a finished response waits in the
// output register while the next request is accepted.

module double_hash_lookup_insert import dhl_pkg::*; #(
   parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [KEY_W-1:0]      req_key,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [SLOT_W-1:0]     rsp_slot,
   output logic [STAT_W-1:0]     rsp_status
);

   dhl_cmd_type cmd;
   dhl_sts_type sts;

   dhl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   dhl_dp #(
      .MAX_SLOTS (MAX_SLOTS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_key    (req_key),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_slot   (rsp_slot),
      .rsp_status (rsp_status)
   );

endmodule
